// ===== rtl/core/taab_pkg.sv =====
// Package for the tilt angle average bar block.
// Holds the payload structs, the CORDIC angle table and the sequencer states.
// No dependencies.
`timescale 1ns / 1ps
package taab_pkg;

    typedef struct packed {
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_z;
    } in_item_t;

    typedef struct packed {
        logic signed [16:0] mean_pitch;
        logic [8:0]         bar_length;
    } out_item_t;

    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = 5;
    localparam int ACC_W        = 31;
    localparam int VEC_W        = 27;
    localparam logic signed [ACC_W-1:0] Q28_HALF_PI = 31'sd421657428;
    localparam int DEG_NUM      = 573;
    localparam int DEG_DEN      = 10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ITER,
        ST_SCALE,
        ST_DEG,
        ST_RING,
        ST_DIV,
        ST_OUT
    } state_t;

    // Arctangent of 2^-i in unsigned Q28 radians.
    function automatic logic [27:0] atan_q28(input logic [STEP_W-1:0] i);
        logic [27:0] r;
        begin
            case (i)
                5'd0:  r = 28'd210828714;
                5'd1:  r = 28'd124459457;
                5'd2:  r = 28'd65760959;
                5'd3:  r = 28'd33381290;
                5'd4:  r = 28'd16755422;
                5'd5:  r = 28'd8385879;
                5'd6:  r = 28'd4193963;
                5'd7:  r = 28'd2097109;
                5'd8:  r = 28'd1048571;
                5'd9:  r = 28'd524287;
                default: r = 28'd1 << (5'd28 - i);
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/core/tilt_angle_average_bar.sv =====
// Top level of the tilt angle average bar block.
// Uses taab_pkg for payload types, the angle table and states.
`timescale 1ns / 1ps
// Usage:
// The s_ channel takes one transaction per sensor sample holding raw X and Z.
// The m_ channel returns one transaction per sample: the mean pitch of the
// last WINDOW samples in 1/256 degree and a display bar length.
// An item is accepted only while the sequencer is idle. The angle comes from a
// vectoring CORDIC that runs one iteration per cycle. ST_SCALE then
// forms the scaled angle, a restoring divide by ten turns it into degrees,
// ST_RING updates the ring, and a restoring divide by WINDOW retires one
// quotient bit per cycle. ST_OUT loads the result register and raises
// m_valid, after which the sequencer returns to idle and can accept the
// next sample; a new sample is not taken before the last one is through.
// Reset (synchronous, active-low aresetn) clears the ring, its running sum
// and the write slot, so the first means are taken over zeros.
// When the receiver stalls, the result register holds its transaction with
// m_valid high. The next sample is still accepted and computed, and its
// result waits in the last sequencer state until the register is taken.
module tilt_angle_average_bar #(
    parameter int WINDOW = 5,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  taab_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output taab_pkg::out_item_t  m_data
);
    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = 22;
    localparam int QW     = 21;
    localparam int QCW    = $clog2(QW + 1);
    localparam int ACC_W  = taab_pkg::ACC_W;
    localparam int VEC_W  = taab_pkg::VEC_W;
    localparam int NUM_W  = ACC_W + 10;

    taab_pkg::state_t state_reg, state_next;

    logic signed [VEC_W-1:0]  cx_reg, cy_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [taab_pkg::STEP_W-1:0] step_reg;
    logic                     x_neg_reg, zero_ang_reg;
    logic signed [16:0]       pitch_ring_reg [WINDOW];
    logic [SLOT_W-1:0]        write_slot_reg;
    logic signed [SUM_W-1:0]  ring_sum_reg;
    logic [QW-1:0]            rem_reg, quo_reg;
    logic [QCW-1:0]           qcnt_reg;
    logic                     sum_neg_reg;
    taab_pkg::out_item_t      out_reg;
    logic                     m_valid_reg;

    // One CORDIC micro-rotation with floor shifts.
    logic signed [VEC_W-1:0] sh_x, sh_y;
    logic signed [ACC_W-1:0] atan_v;
    assign sh_x   = cx_reg >>> step_reg;
    assign sh_y   = cy_reg >>> step_reg;
    assign atan_v = ACC_W'(taab_pkg::atan_q28(step_reg));

    // Angle times 57.3 with the half-LSB rounding offset, ready for the
    // divide by ten; dropping the low Q28 bits first leaves the quotient exact.
    logic [ACC_W-1:0]        theta;
    logic [NUM_W-1:0]        num;
    logic [QW-1:0]           deg_t;
    assign theta = (acc_reg < 0 || zero_ang_reg) ? '0 : acc_reg;
    assign num   = NUM_W'(theta) * NUM_W'(taab_pkg::DEG_NUM);
    assign deg_t = QW'(num >> (28 - ANGLE_FRAC_BITS)) + QW'(taab_pkg::DEG_DEN / 2);

    // Signed pitch from the degree quotient, and the new ring sum.
    logic signed [16:0]      pitch;
    logic signed [SUM_W-1:0] sum_new;
    assign pitch   = x_neg_reg ? $signed(quo_reg[16:0]) : -$signed(quo_reg[16:0]);
    assign sum_new = ring_sum_reg - SUM_W'(pitch_ring_reg[write_slot_reg]) + SUM_W'(pitch);

    // One restoring divide step, by ten for degrees or by WINDOW for the mean.
    logic [QW:0]   divisor;
    logic [QW:0]   trial;
    logic [QW-1:0] rem_step, quo_step;
    assign divisor  = (state_reg == taab_pkg::ST_DEG) ? (QW+1)'(taab_pkg::DEG_DEN) :
                                                        (QW+1)'(WINDOW);
    assign trial    = {rem_reg, quo_reg[QW-1]} - divisor;
    assign rem_step = trial[QW] ? {rem_reg[QW-2:0], quo_reg[QW-1]} : trial[QW-1:0];
    assign quo_step = {quo_reg[QW-2:0], !trial[QW]};

    logic [16:0] mean_mag;
    logic signed [16:0] mean_s;
    assign mean_mag = quo_reg[16:0];
    assign mean_s   = sum_neg_reg ? -$signed(mean_mag) : $signed(mean_mag);

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= taab_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            taab_pkg::ST_IDLE:  if (s_valid) state_next = taab_pkg::ST_ITER;
            taab_pkg::ST_ITER:  if (step_reg == 5'(taab_pkg::CORDIC_STEPS - 1))
                                    state_next = taab_pkg::ST_SCALE;
            taab_pkg::ST_SCALE: state_next = taab_pkg::ST_DEG;
            taab_pkg::ST_DEG:   if (qcnt_reg == QCW'(QW - 1)) state_next = taab_pkg::ST_RING;
            taab_pkg::ST_RING:  state_next = taab_pkg::ST_DIV;
            taab_pkg::ST_DIV:   if (qcnt_reg == QCW'(QW - 1)) state_next = taab_pkg::ST_OUT;
            taab_pkg::ST_OUT:   if (!m_valid_reg || m_ready) state_next = taab_pkg::ST_IDLE;
            default:            state_next = taab_pkg::ST_IDLE;
        endcase
    end

    assign s_ready = (state_reg == taab_pkg::ST_IDLE);

    // Datapath and ring state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) pitch_ring_reg[i] <= '0;
            write_slot_reg <= '0;
            ring_sum_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            // The result register is refilled when free or drained this cycle.
            if (state_reg == taab_pkg::ST_OUT && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                taab_pkg::ST_IDLE: begin
                    if (s_valid) begin
                        x_neg_reg    <= s_data.accel_x[15];
                        zero_ang_reg <= (s_data.accel_x == 16'sd0) && !s_data.accel_z[15];
                        step_reg     <= '0;
                        if (s_data.accel_z[15]) begin
                            cx_reg  <= VEC_W'($signed({s_data.accel_x[15] ?
                                       -{s_data.accel_x[15], s_data.accel_x} :
                                       {s_data.accel_x[15], s_data.accel_x}, 8'd0}));
                            cy_reg  <= VEC_W'($signed({-{s_data.accel_z[15],
                                       s_data.accel_z}, 8'd0}));
                            acc_reg <= taab_pkg::Q28_HALF_PI;
                        end else begin
                            cx_reg  <= VEC_W'($signed({{s_data.accel_z[15], s_data.accel_z},
                                       8'd0}));
                            cy_reg  <= VEC_W'($signed({s_data.accel_x[15] ?
                                       -{s_data.accel_x[15], s_data.accel_x} :
                                       {s_data.accel_x[15], s_data.accel_x}, 8'd0}));
                            acc_reg <= '0;
                        end
                    end
                end
                taab_pkg::ST_ITER: begin
                    if (cy_reg >= 0) begin
                        cx_reg  <= cx_reg + sh_y;
                        cy_reg  <= cy_reg - sh_x;
                        acc_reg <= acc_reg + atan_v;
                    end else begin
                        cx_reg  <= cx_reg - sh_y;
                        cy_reg  <= cy_reg + sh_x;
                        acc_reg <= acc_reg - atan_v;
                    end
                    step_reg <= step_reg + 1'b1;
                end
                taab_pkg::ST_SCALE: begin
                    quo_reg  <= deg_t;
                    rem_reg  <= '0;
                    qcnt_reg <= '0;
                end
                taab_pkg::ST_DEG: begin
                    rem_reg  <= rem_step;
                    quo_reg  <= quo_step;
                    qcnt_reg <= qcnt_reg + 1'b1;
                end
                taab_pkg::ST_RING: begin
                    pitch_ring_reg[write_slot_reg] <= pitch;
                    ring_sum_reg   <= sum_new;
                    write_slot_reg <= (write_slot_reg == SLOT_W'(WINDOW - 1)) ?
                                      '0 : write_slot_reg + 1'b1;
                    sum_neg_reg    <= sum_new[SUM_W-1];
                    quo_reg        <= QW'(sum_new[SUM_W-1] ? -sum_new : sum_new);
                    rem_reg        <= '0;
                    qcnt_reg       <= '0;
                end
                taab_pkg::ST_DIV: begin
                    rem_reg  <= rem_step;
                    quo_reg  <= quo_step;
                    qcnt_reg <= qcnt_reg + 1'b1;
                end
                taab_pkg::ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.mean_pitch    <= mean_s;
                        out_reg.bar_length    <= 9'({mean_mag >> ANGLE_FRAC_BITS, 1'b0});
                    end
                end
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
endmodule

// ===== rtl/core/taab_checker.sv =====
// Port-level checker for the tilt angle average bar block.
// Uses taab_pkg types; bound to tilt_angle_average_bar.
`timescale 1ns / 1ps
module taab_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input taab_pkg::out_item_t m_data
);
    // A stalled result holds its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data)) else $error("result changed");

    // No sample is taken the cycle after one was accepted.
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("back to back accept");

    // The bar length is always even.
    a_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_data.bar_length[0]) else $error("odd bar length");

    // Nothing is shown right after reset.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid) else $error("valid after reset");
endmodule

bind tilt_angle_average_bar taab_checker u_taab_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
);
